// File: sv/pgf_pkg.sv
// Shared constants, types and helpers for the pairwise gravity force block.
package pgf_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  localparam int FIFO_DEPTH = 2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_SQ = 1'b1;

  localparam int FORCE_W = 48;
  localparam int ACC_W   = FORCE_W + IDX_W + 1;
  localparam int Q_W     = FORCE_W - 1;
  localparam int NUM_W   = 111;
  localparam int DEN_W   = 82;
  localparam int DQ_W    = 50;

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [31:0]      pos_z;
    logic [31:0]      mass;
    logic             immovable;
    logic             last;
    logic             store;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } pgf_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] mass;
    logic        fixed;
  } pgf_part_t;

  function automatic logic signed [FORCE_W-1:0] sat_force(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(FORCE_MAX);
    lo = ACC_W'(FORCE_MIN);
    if (v > hi) begin
      return FORCE_MAX;
    end else if (v < lo) begin
      return FORCE_MIN;
    end else begin
      return v[FORCE_W-1:0];
    end
  endfunction

endpackage

// File: sv/pgf_fifo.sv
// Short item queue between the load front end and the force engine.
module pgf_fifo import pgf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pgf_item_t push_data,
  output logic      full,
  input  logic      pop,
  output pgf_item_t pop_data,
  output logic      valid
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  pgf_item_t          ent_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [FCNT_W-1:0]  cnt_r;

  assign full     = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/pgf_front.sv
// Load front end: accepts particles, assigns slots, drops overflow, marks batch end.
module pgf_front import pgf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [31:0]        in_mass,
  input  logic               in_immovable,
  input  logic               in_last_particle,
  input  logic               fifo_full,
  output logic               push,
  output pgf_item_t          push_data
);

  logic [CNT_W-1:0] cnt_r;
  logic             store;
  logic [CNT_W-1:0] cnt_after;

  assign in_ready  = !fifo_full;
  assign push      = in_valid && in_ready;
  assign store     = (cnt_r < CNT_W'(MAX_PARTICLES));
  assign cnt_after = store ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    push_data.pos_x     = in_pos_x;
    push_data.pos_y     = in_pos_y;
    push_data.pos_z     = in_pos_z;
    push_data.mass      = in_mass;
    push_data.immovable = in_immovable;
    push_data.last      = in_last_particle;
    push_data.store     = store;
    push_data.idx       = cnt_r[IDX_W-1:0];
    push_data.count     = cnt_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= in_last_particle ? '0 : cnt_after;
    end
  end

endmodule

// File: sv/pgf_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module pgf_isqrt import pgf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign root  = res_r[31:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= val;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        cnt_r  <= 5'd31;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/pgf_div.sv
// Restoring divider with saturation at the force term limit, one quotient bit per cycle.
module pgf_div import pgf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             done
);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   q_r;
  logic [5:0]       cnt_r;
  logic             sat_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, low_r[Q_W-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign quo   = sat_r ? {Q_W{1'b1}} : q_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r  <= den;
        sat_r  <= (DEN_W'(num[NUM_W-1:Q_W]) >= den);
        rem_r  <= DEN_W'(num[NUM_W-1:Q_W]);
        low_r  <= num[Q_W-1:0];
        q_r    <= '0;
        cnt_r  <= 6'(Q_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= DEN_W'(trial - {1'b0, den_r});
        end else begin
          rem_r <= trial[DEN_W-1:0];
        end
        q_r   <= {q_r[Q_W-2:0], fits};
        low_r <= {low_r[Q_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/pgf_engine.sv
// Force engine: particle store, pair sequencer, shared multiplier, accumulators, result register.
module pgf_engine import pgf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [31:0]               grav_const,
  input  logic [31:0]               min_dist_sq,
  input  logic                      item_valid,
  input  pgf_item_t                 item,
  output logic                      item_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_particle_index,
  output logic signed [FORCE_W-1:0] out_force_x,
  output logic signed [FORCE_W-1:0] out_force_y,
  output logic signed [FORCE_W-1:0] out_force_z,
  output logic                      out_last_result
);

  typedef enum logic [4:0] {
    S_IDLE, S_RDI, S_GM, S_GM2, S_JWAIT, S_JCHK, S_SQ0, S_SQ1, S_SQ2, S_SQ3,
    S_FLOOR, S_SQST, S_SQRT, S_K0, S_K1, S_K2, S_DEN0, S_DEN1, S_DEN2,
    S_N0, S_N1, S_N2, S_DIV, S_DIVW, S_NEXTJ, S_OUT
  } state_t;

  state_t state_r;

  pgf_part_t mem [MAX_PARTICLES];
  pgf_part_t rd_i_r;
  pgf_part_t rd_j_r;

  logic [CNT_W-1:0]        n_r;
  logic [IDX_W-1:0]        i_r;
  logic [IDX_W-1:0]        j_r;
  logic [63:0]             gm_r;
  logic signed [ACC_W-1:0] acc_r [3];
  logic                    sgn_r [3];
  logic [31:0]             ad_r [3];
  logic [65:0]             sq_r;
  logic [DQ_W-1:0]         dq_r;
  logic [31:0]             r_r;
  logic [63:0]             kq_r;
  logic [63:0]             prod_r;
  logic [DEN_W-1:0]        den_r;
  logic [NUM_W-1:0]        num_r [3];
  logic [1:0]              ax_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p_r;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [FORCE_W-1:0] out_fx_r;
  logic signed [FORCE_W-1:0] out_fy_r;
  logic signed [FORCE_W-1:0] out_fz_r;
  logic                    out_last_r;

  logic              sq_start;
  logic [31:0]       sq_root;
  logic              sq_done;
  logic              div_start;
  logic [Q_W-1:0]    quo [3];
  logic              div_done [3];

  logic [31:0]       pi [3];
  logic [31:0]       pj [3];
  logic signed [32:0] diff [3];
  logic [95:0]       wide_sum;
  logic [DQ_W-1:0]   dq_raw;
  logic [DQ_W-1:0]   dq_floor;
  logic              out_free;

  assign item_pop  = (state_r == S_IDLE) && item_valid;
  assign sq_start  = (state_r == S_SQST);
  assign div_start = (state_r == S_DIV);
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_particle_index = out_idx_r;
  assign out_force_x        = out_fx_r;
  assign out_force_y        = out_fy_r;
  assign out_force_z        = out_fz_r;
  assign out_last_result    = out_last_r;

  always_ff @(posedge clk) begin
    if (item_pop && item.store) begin
      mem[item.idx] <= '{x: item.pos_x, y: item.pos_y, z: item.pos_z,
                         mass: item.mass, fixed: item.immovable};
    end
    rd_i_r <= mem[i_r];
    rd_j_r <= mem[j_r];
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  always_comb begin
    pi[0] = rd_i_r.x;
    pi[1] = rd_i_r.y;
    pi[2] = rd_i_r.z;
    pj[0] = rd_j_r.x;
    pj[1] = rd_j_r.y;
    pj[2] = rd_j_r.z;
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({pj[c][31], pj[c]}) - $signed({pi[c][31], pi[c]});
    end
  end

  always_comb begin
    dq_raw   = sq_r[65:16];
    dq_floor = DQ_W'((min_dist_sq == '0) ? 32'd1 : min_dist_sq);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_GM: begin
        mul_a = grav_const;
        mul_b = rd_i_r.mass;
      end
      S_SQ0: begin
        mul_a = ad_r[0];
        mul_b = ad_r[0];
      end
      S_SQ1: begin
        mul_a = ad_r[1];
        mul_b = ad_r[1];
      end
      S_SQ2: begin
        mul_a = ad_r[2];
        mul_b = ad_r[2];
      end
      S_K0: begin
        mul_a = gm_r[31:0];
        mul_b = rd_j_r.mass;
      end
      S_K1: begin
        mul_a = gm_r[63:32];
        mul_b = rd_j_r.mass;
      end
      S_DEN0: begin
        mul_a = dq_r[31:0];
        mul_b = r_r;
      end
      S_DEN1: begin
        mul_a = 32'(dq_r[DQ_W-1:32]);
        mul_b = r_r;
      end
      S_N0: begin
        mul_a = kq_r[31:0];
        mul_b = ad_r[ax_r];
      end
      S_N1: begin
        mul_a = kq_r[63:32];
        mul_b = ad_r[ax_r];
      end
      default: ;
    endcase
  end

  assign wide_sum = {32'b0, prod_r} + {mul_p_r, 32'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      ax_r        <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (item_valid && item.last && item.count != '0) begin
            n_r     <= item.count;
            i_r     <= '0;
            state_r <= S_RDI;
          end
        end
        S_RDI: state_r <= S_GM;
        S_GM:  state_r <= S_GM2;
        S_GM2: begin
          gm_r <= mul_p_r;
          for (int c = 0; c < 3; c++) begin
            acc_r[c] <= '0;
          end
          j_r     <= '0;
          state_r <= rd_i_r.fixed ? S_OUT : S_JWAIT;
        end
        S_JWAIT: state_r <= S_JCHK;
        S_JCHK: begin
          if (j_r == i_r || rd_j_r.fixed) begin
            state_r <= S_NEXTJ;
          end else begin
            for (int c = 0; c < 3; c++) begin
              sgn_r[c] <= diff[c][32];
              ad_r[c]  <= diff[c][32] ? 32'(-diff[c]) : diff[c][31:0];
            end
            state_r <= S_SQ0;
          end
        end
        S_SQ0: state_r <= S_SQ1;
        S_SQ1: begin
          sq_r    <= {2'b0, mul_p_r};
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          sq_r    <= sq_r + {2'b0, mul_p_r};
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          sq_r    <= sq_r + {2'b0, mul_p_r};
          state_r <= S_FLOOR;
        end
        S_FLOOR: begin
          dq_r    <= (dq_raw < dq_floor) ? dq_floor : dq_raw;
          state_r <= S_SQST;
        end
        S_SQST: state_r <= S_SQRT;
        S_SQRT: begin
          if (sq_done) begin
            r_r     <= sq_root;
            state_r <= S_K0;
          end
        end
        S_K0: state_r <= S_K1;
        S_K1: begin
          prod_r  <= mul_p_r;
          state_r <= S_K2;
        end
        S_K2: begin
          kq_r    <= wide_sum[95:32];
          state_r <= S_DEN0;
        end
        S_DEN0: state_r <= S_DEN1;
        S_DEN1: begin
          prod_r  <= mul_p_r;
          state_r <= S_DEN2;
        end
        S_DEN2: begin
          den_r   <= wide_sum[DEN_W-1:0];
          ax_r    <= '0;
          state_r <= S_N0;
        end
        S_N0: state_r <= S_N1;
        S_N1: begin
          prod_r  <= mul_p_r;
          state_r <= S_N2;
        end
        S_N2: begin
          num_r[ax_r] <= {wide_sum, 15'b0};
          if (ax_r == 2'd2) begin
            state_r <= S_DIV;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= S_N0;
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done[0] && div_done[1] && div_done[2]) begin
            for (int c = 0; c < 3; c++) begin
              acc_r[c] <= sgn_r[c] ? acc_r[c] - $signed(ACC_W'(quo[c]))
                                   : acc_r[c] + $signed(ACC_W'(quo[c]));
            end
            state_r <= S_NEXTJ;
          end
        end
        S_NEXTJ: begin
          if (CNT_W'(j_r) + 1'b1 == n_r) begin
            state_r <= S_OUT;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_JWAIT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= i_r;
            out_fx_r    <= sat_force(acc_r[0]);
            out_fy_r    <= sat_force(acc_r[1]);
            out_fz_r    <= sat_force(acc_r[2]);
            out_last_r  <= (CNT_W'(i_r) + 1'b1 == n_r);
            if (CNT_W'(i_r) + 1'b1 == n_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_RDI;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  pgf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   ({dq_r, 14'b0}),
    .root  (sq_root),
    .done  (sq_done)
  );

  for (genvar c = 0; c < 3; c++) begin : g_div
    pgf_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (num_r[c]),
      .den   (den_r),
      .quo   (quo[c]),
      .done  (div_done[c])
    );
  end

endmodule

// File: sv/pairwise_gravity_force_top.sv
// Top level of the direct-sum N-body gravity force block.
// Input channel (in_valid/in_ready): one particle per transfer, stored in load
// order; a particle beyond the 64-slot capacity is dropped. The transfer with
// in_last_particle set ends the batch and starts the force pass.
// Result channel (out_valid/out_ready): one transfer per stored particle, in
// load order, with out_last_result on the final one. No results for an empty
// batch or for non-final items.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0: G,
// 1: distance floor) in the same cycle; write only while the block is idle.
// A two-entry queue decouples loading from the force engine. Each interacting
// pair runs through the shared multiplier, the 32-step square root and the
// 47-step dividers; a skipped pair (self or immovable) bypasses them, and an
// immovable particle skips its pair loop. Results come out one particle at a
// time, each once all of its pairs are done.
// Reset (synchronous, rst_n low) empties the queue, clears the load count and
// restores G = 1.0 and floor = 1 LSB. A stalled receiver holds the result
// register and stops the engine at the next result; loading continues until
// the queue fills.
module pairwise_gravity_force_top import pgf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        in_pos_x,
  input  logic signed [31:0]        in_pos_y,
  input  logic signed [31:0]        in_pos_z,
  input  logic [31:0]               in_mass,
  input  logic                      in_immovable,
  input  logic                      in_last_particle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_particle_index,
  output logic signed [FORCE_W-1:0] out_force_x,
  output logic signed [FORCE_W-1:0] out_force_y,
  output logic signed [FORCE_W-1:0] out_force_z,
  output logic                      out_last_result,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]               cfg_wdata
);

  logic [31:0] grav_const_r;
  logic [31:0] min_dist_sq_r;

  logic      push;
  pgf_item_t push_data;
  logic      fifo_full;
  logic      pop;
  pgf_item_t pop_data;
  logic      fifo_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_const_r  <= 32'd65536;
      min_dist_sq_r <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAV_CONST:  grav_const_r  <= cfg_wdata;
        REG_MIN_DIST_SQ: min_dist_sq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pgf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_mass          (in_mass),
    .in_immovable     (in_immovable),
    .in_last_particle (in_last_particle),
    .fifo_full        (fifo_full),
    .push             (push),
    .push_data        (push_data)
  );

  pgf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .valid     (fifo_valid)
  );

  pgf_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .grav_const         (grav_const_r),
    .min_dist_sq        (min_dist_sq_r),
    .item_valid         (fifo_valid),
    .item               (pop_data),
    .item_pop           (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_particle_index (out_particle_index),
    .out_force_x        (out_force_x),
    .out_force_y        (out_force_y),
    .out_force_z        (out_force_z),
    .out_last_result    (out_last_result)
  );

endmodule

// File: tb/sv/tb_pairwise_gravity_force_top.sv
// Self-checking testbench for pairwise_gravity_force_top: directed table, random batches.
module tb_pairwise_gravity_force_top;
  import pgf_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam longint FMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint FMIN = -64'sh8000_0000_0000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] m;
    logic        imm;
    logic        last;
    logic        zero_forces;
  } load_row_t;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [FORCE_W-1:0] fx;
    logic [FORCE_W-1:0] fy;
    logic [FORCE_W-1:0] fz;
    logic               last;
  } force_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic [31:0] in_mass;
  logic in_immovable;
  logic in_last_particle;
  logic out_valid;
  logic out_ready;
  logic [IDX_W-1:0] out_particle_index;
  logic signed [FORCE_W-1:0] out_force_x;
  logic signed [FORCE_W-1:0] out_force_y;
  logic signed [FORCE_W-1:0] out_force_z;
  logic out_last_result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  pairwise_gravity_force_top u_top (.*);

  // predictor state
  logic [31:0] g_val;
  logic [31:0] floor_val;
  logic [31:0] px [MAX_PARTICLES];
  logic [31:0] py [MAX_PARTICLES];
  logic [31:0] pz [MAX_PARTICLES];
  logic [31:0] pm [MAX_PARTICLES];
  logic        pfix [MAX_PARTICLES];
  int          n_loaded;

  force_res_t pending_forces[$];
  int errors;
  int loads_done;
  int forces_seen;
  int batches_done;
  int snd_pct;
  int rcv_pct;
  int hold_left;
  bit hold_req;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void add_pair_force(int i, int j, ref longint acc[3]);
    longint d[3];
    logic [127:0] ad;
    logic [127:0] sq;
    logic [63:0] dq;
    logic [63:0] r;
    logic [127:0] kq;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] fl;
    longint t;
    d[0] = longint'($signed(px[j])) - longint'($signed(px[i]));
    d[1] = longint'($signed(py[j])) - longint'($signed(py[i]));
    d[2] = longint'($signed(pz[j])) - longint'($signed(pz[i]));
    sq = 0;
    for (int c = 0; c < 3; c++) begin
      ad = d[c] < 0 ? 128'(-d[c]) : 128'(d[c]);
      sq = sq + ad * ad;
    end
    dq = sq[79:16];
    fl = (floor_val == 0) ? 128'd1 : 128'(floor_val);
    if (128'(dq) < fl) dq = fl[63:0];
    r = isqrt64(dq << 14);
    kq = (128'(g_val) * 128'(pm[i]) * 128'(pm[j])) >> 32;
    kq = 128'(kq[63:0]);
    den = 128'(dq) * 128'(r);
    for (int c = 0; c < 3; c++) begin
      ad = d[c] < 0 ? 128'(-d[c]) : 128'(d[c]);
      if (ad != 0 && kq != 0) begin
        q = ((kq * ad) << 15) / den;
        t = (q > 128'(FMAX)) ? FMAX : longint'(q[63:0]);
        acc[c] += (d[c] < 0) ? -t : t;
      end
    end
  endfunction

  function automatic logic [FORCE_W-1:0] clamp48(longint v);
    if (v > FMAX) return FMAX[FORCE_W-1:0];
    if (v < FMIN) return FMIN[FORCE_W-1:0];
    return v[FORCE_W-1:0];
  endfunction

  // store one particle; on the batch end, queue the force of every stored particle
  function automatic void compute_batch_forces(load_row_t row);
    force_res_t f;
    longint acc[3];
    if (n_loaded < MAX_PARTICLES) begin
      px[n_loaded] = row.x;
      py[n_loaded] = row.y;
      pz[n_loaded] = row.z;
      pm[n_loaded] = row.m;
      pfix[n_loaded] = row.imm;
      n_loaded++;
    end
    if (!row.last) return;
    for (int i = 0; i < n_loaded; i++) begin
      acc = '{0, 0, 0};
      if (!pfix[i]) begin
        for (int j = 0; j < n_loaded; j++) begin
          if (j != i && !pfix[j]) add_pair_force(i, j, acc);
        end
      end
      f.idx = i[IDX_W-1:0];
      f.fx = clamp48(acc[0]);
      f.fy = clamp48(acc[1]);
      f.fz = clamp48(acc[2]);
      f.last = (i + 1 == n_loaded);
      if (row.zero_forces) begin
        f.fx = '0;
        f.fy = '0;
        f.fz = '0;
      end
      pending_forces.insert(pending_forces.size(), f);
    end
    n_loaded = 0;
    batches_done++;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, forces_seen);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    force_res_t e;
    if (rst_n && out_valid && out_ready) begin
      forces_seen++;
      if (pending_forces.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_particle_index), 64'h0);
      end else begin
        e = pending_forces.pop_front();
        if (out_particle_index !== e.idx)
          report_mismatch("particle_index", 64'(out_particle_index), 64'(e.idx));
        if (out_force_x !== e.fx) report_mismatch("force_x", 64'(out_force_x), 64'(e.fx));
        if (out_force_y !== e.fy) report_mismatch("force_y", 64'(out_force_y), 64'(e.fy));
        if (out_force_z !== e.fz) report_mismatch("force_z", 64'(out_force_z), 64'(e.fz));
        if (out_last_result !== e.last)
          report_mismatch("last_result", 64'(out_last_result), 64'(e.last));
      end
    end
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 2000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("pairwise_gravity_force_top regression: fail");
        $finish;
      end
    end
  end

  task automatic send_load(load_row_t row);
    if ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= row.x;
    in_pos_y <= row.y;
    in_pos_z <= row.z;
    in_mass <= row.m;
    in_immovable <= row.imm;
    in_last_particle <= row.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_batch_forces(row);
    loads_done++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRAV_CONST) g_val = v;
    else floor_val = v;
  endtask

  function automatic load_row_t rand_particle(int style, logic [31:0] bx, logic [31:0] by,
                                              logic [31:0] bz, bit last);
    load_row_t p;
    case (style)
      0: begin
        p.x = $urandom;
        p.y = $urandom;
        p.z = $urandom;
      end
      1: begin
        p.x = bx + $urandom_range(0, 1 << 19) - (1 << 18);
        p.y = by + $urandom_range(0, 1 << 19) - (1 << 18);
        p.z = bz + $urandom_range(0, 1 << 19) - (1 << 18);
      end
      default: begin
        p.x = bx + $urandom_range(0, 8) - 4;
        p.y = by + $urandom_range(0, 8) - 4;
        p.z = bz + $urandom_range(0, 8) - 4;
      end
    endcase
    p.m = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 10, 1 << 20);
    p.imm = ($urandom_range(99) < 15);
    p.last = last;
    p.zero_forces = 1'b0;
    return p;
  endfunction

  task automatic rand_batch(int n, int movable);
    int style;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
    load_row_t p;
    style = $urandom_range(2);
    bx = $urandom;
    by = $urandom;
    bz = $urandom;
    for (int k = 0; k < n; k++) begin
      p = rand_particle(style, bx, by, bz, k == n - 1);
      if (movable >= 0) p.imm = (k >= movable);
      send_load(p);
    end
  endtask

  load_row_t directed[$];
  logic [31:0] g_set[6];
  logic [31:0] f_set[6];

  function automatic void table_add(load_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  initial begin
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_mass = '0;
    in_immovable = 1'b0;
    in_last_particle = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    g_val = 32'd65536;
    floor_val = 32'd1;
    n_loaded = 0;
    errors = 0;
    loads_done = 0;
    forces_seen = 0;
    batches_done = 0;
    hold_left = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    snd_pct = 27;
    rcv_pct = 65;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone particle, coincident pair, all-immovable, zero mass: no force
    table_add('{32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0, 1'b1, 1'b1});
    table_add('{32'h5, 32'h5, 32'h5, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0});
    table_add('{32'h5, 32'h5, 32'h5, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1});
    table_add('{32'h100, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b0, 1'b0});
    table_add('{32'h0, 32'h200, 32'h0, 32'h0001_0000, 1'b1, 1'b1, 1'b1});
    table_add('{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0});
    table_add('{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0, 1'b1, 1'b1});
    // extreme positions and masses
    table_add('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                1'b0, 1'b0, 1'b0});
    table_add('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                1'b0, 1'b1, 1'b0});
    // one LSB apart: hits the distance floor, heavy masses saturate
    table_add('{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0});
    table_add('{32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0});
    table_add('{32'h2, 32'h1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0});
    // immovable target between movable ones
    table_add('{32'h0003_0000, 32'h0, 32'h0, 32'h0002_0000, 1'b0, 1'b0, 1'b0});
    table_add('{32'h0, 32'h0, 32'h0, 32'h0100_0000, 1'b1, 1'b0, 1'b0});
    table_add('{32'hFFFD_0000, 32'h0001_0000, 32'h0, 32'h0002_0000, 1'b0, 1'b1, 1'b0});
    foreach (directed[k]) send_load(directed[k]);

    g_set = '{32'd65536, 32'hFFFF_FFFF, 32'h0, $urandom, 32'd65536, $urandom_range(1, 1 << 20)};
    f_set = '{32'd1, 32'h0, 32'hFFFF_FFFF, $urandom, 32'd65536, 32'd1};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        snd_pct = 65;
        rcv_pct = 27;
      end else if (ph == 4) begin
        snd_pct = 0;
        rcv_pct = 0;
      end
      if (ph > 0) begin
        drain_results();
        write_reg(REG_GRAV_CONST, g_set[ph]);
        write_reg(REG_MIN_DIST_SQ, f_set[ph]);
      end
      if (ph == 4) begin
        // past capacity: 64 stored, the rest dropped, a dropped one ends the batch
        for (int k = 0; k < 70; k++) begin
          send_load('{$urandom, $urandom, $urandom, $urandom, k >= 4, k == 69, 1'b0});
        end
      end
      if (ph == 5) begin
        rand_batch(16, 16);
        drain_results();
        // long receiver hold-off while loads keep coming
        hold_req = 1'b1;
        for (int k = 0; k < 4; k++) rand_batch(2, 2);
      end
      target = loads_done + 60;
      while (loads_done < target) rand_batch($urandom_range(1, 6), -1);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d particle loads in %0d batches, %0d force results checked,",
             loads_done, batches_done, forces_seen);
    $display("six G/floor settings incl. extremes, overflow past capacity, stalls both sides");
    if (errors == 0 && pending_forces.size() == 0) begin
      $display("pairwise_gravity_force_top regression: pass");
    end else begin
      $display("pairwise_gravity_force_top regression: fail");
    end
    $finish;
  end

endmodule
